[src/pre_pkg.sv]
// Shared constants and codes of the page replacement engine.
package pre_pkg;

  localparam int unsigned CFG_W     = 7;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned VPAGE_W   = 22;
  localparam logic [4:0]  MIN_SHIFT = 5'd10;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_POLICY      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAGE_SHIFT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT = 2'd2;

  // Replacement policy codes; the unused code behaves as LRU.
  localparam logic [1:0] POL_LRU   = 2'd0;
  localparam logic [1:0] POL_CLOCK = 2'd1;
  localparam logic [1:0] POL_NRU   = 2'd2;

endpackage

[src/pre_ram.sv]
// Generic simple dual-port RAM with one write port and one registered read port.
module pre_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[src/page_replacement_engine.sv]
// Top level of the page replacement engine: frame table sequencer and its two RAMs.
//
// An access word (address_i, is_write_i) is taken at a clock edge where start is
// high and busy is low. The page number is the address shifted right by the
// page_shift register (never less than ten). The engine looks the page up in its
// frame table, fills a free frame on a miss while fewer than frame_count frames
// are filled, and otherwise replaces a victim chosen by the policy register
// (LRU, clock second chance or NRU). One result word per access appears for
// exactly one cycle with done_o high; the receiver cannot stall it.
//
// Each access runs as sequential sweeps through the frame RAMs: the tag search
// (A active frames), the LRU/NRU scan on a full miss and the age update sweep
// over all filled frames read one entry per cycle; on a full miss under clock
// the sweep reads and then judges each frame it visits. A hit or an eviction
// also reads the chosen frame before the age sweep, and a finish state follows.
// Busy stays high meanwhile.
//
// Reset clears the counters, fill count, clock hand and registers to their
// defaults. Frame RAM contents are only read below the fill count, so they need
// no clearing pass. Configuration writes are taken in any cycle but are meant
// for idle periods only.
module page_replacement_engine #(
  parameter int unsigned NUM_FRAMES = 64,
  parameter int unsigned ADDR_BITS  = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pre_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pre_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic                           start,
  output logic                           busy,
  input  logic [ADDR_BITS-1:0]           address_i,
  input  logic                           is_write_i,
  output logic                           done_o,
  output logic                           hit_o,
  output logic                           evicted_o,
  output logic                           writeback_o,
  output logic [pre_pkg::VPAGE_W-1:0]    victim_page_o,
  output logic [31:0]                    hit_total_o,
  output logic [31:0]                    fault_total_o,
  output logic [31:0]                    writeback_total_o
);
  import pre_pkg::*;

  localparam int unsigned IW     = $clog2(NUM_FRAMES);
  localparam int unsigned CNT_W  = $clog2(NUM_FRAMES + 1);
  localparam int unsigned AGE_W  = IW;
  localparam int unsigned KW     = AGE_W + 2;
  localparam int unsigned PAGE_W = ADDR_BITS - 10;
  localparam int unsigned CW     = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam logic [AGE_W-1:0] AGE_CAP = AGE_W'(NUM_FRAMES - 1);

  // Per-frame status word kept in the status RAM.
  typedef struct packed {
    logic             refd;
    logic             dirty;
    logic [AGE_W-1:0] age;
  } fstat_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SRCH, ST_SCAN, ST_CLK_RD, ST_CLK_EV, ST_RDF, ST_GETF, ST_AGE, ST_DONE
  } state_e;

  state_e state_q;

  logic [1:0]         policy_q;
  logic [4:0]         page_shift_q;
  logic [CFG_W-1:0]   frame_count_q;

  logic [PAGE_W-1:0]  page_q;
  logic               wr_q;
  logic [CNT_W-1:0]   active_q, eff_q, filled_q, rd_cnt_q;
  logic               cmp_vld_q;
  logic [IW-1:0]      cmp_idx_q, f_q, h_q, hand_q, best_idx_q;
  logic [KW-1:0]      best_key_q;
  logic               best_vld_q;
  logic [AGE_W:0]     old_age_q;
  logic               hit_q, ev_q, wb_q, done_q;
  logic [PAGE_W-1:0]  vpage_q;
  logic [31:0]        hit_cnt_q, fault_cnt_q, wb_cnt_q;

  // RAM ports.
  logic [IW-1:0]      pg_raddr, pg_waddr, b_raddr, b_waddr;
  logic               pg_we, b_we;
  logic [PAGE_W-1:0]  pg_rdata;
  fstat_t             b_rdata, b_wdata;

  // Combinational helpers.
  logic [4:0]         shift_eff;
  logic [PAGE_W-1:0]  page_in;
  logic [CW-1:0]      fc_ext, eff_ext;
  logic [CNT_W-1:0]   eff_in, active_in;
  logic [KW-1:0]      scan_key;
  logic [IW-1:0]      h_start, h_next;
  fstat_t             aged;

  pre_ram #(.WIDTH(PAGE_W), .DEPTH(NUM_FRAMES)) u_page_ram (
    .clk_i   (clk_i),
    .we_i    (pg_we),
    .waddr_i (pg_waddr),
    .wdata_i (page_q),
    .raddr_i (pg_raddr),
    .rdata_o (pg_rdata)
  );

  pre_ram #(.WIDTH(AGE_W + 2), .DEPTH(NUM_FRAMES)) u_stat_ram (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (b_waddr),
    .wdata_i (b_wdata),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  // Page number and effective frame count of the incoming access.
  always_comb begin
    shift_eff = (page_shift_q < MIN_SHIFT) ? MIN_SHIFT : page_shift_q;
    page_in   = PAGE_W'(address_i >> shift_eff);
    fc_ext    = CW'(frame_count_q);
    if (fc_ext == '0) begin
      eff_ext = CW'(1);
    end else if (fc_ext > CW'(NUM_FRAMES)) begin
      eff_ext = CW'(NUM_FRAMES);
    end else begin
      eff_ext = fc_ext;
    end
    eff_in    = CNT_W'(eff_ext);
    active_in = (filled_q < eff_in) ? filled_q : eff_in;
  end

  // Scan key: LRU maximizes age, NRU maximizes the inverted class.
  always_comb begin
    if (policy_q == POL_NRU) begin
      scan_key = KW'(2'd3 - {b_rdata.refd, b_rdata.dirty});
    end else begin
      scan_key = KW'(b_rdata.age);
    end
    h_start = (CNT_W'(hand_q) >= active_q) ? '0 : hand_q;
    h_next  = ((CNT_W'(h_q) + CNT_W'(1)) >= active_q) ? '0 : IW'(h_q + IW'(1));
  end

  // Age update of one entry during the sweep.
  always_comb begin
    aged = b_rdata;
    if (cmp_idx_q == f_q) begin
      aged.refd  = 1'b1;
      aged.dirty = hit_q ? (b_rdata.dirty | wr_q) : wr_q;
      aged.age   = '0;
    end else if (({1'b0, b_rdata.age} < old_age_q) && (b_rdata.age < AGE_CAP)) begin
      aged.age = b_rdata.age + AGE_W'(1);
    end
  end

  // RAM address and write control by sequencer state.
  always_comb begin
    pg_raddr = rd_cnt_q[IW-1:0];
    pg_waddr = f_q;
    pg_we    = 1'b0;
    b_raddr  = rd_cnt_q[IW-1:0];
    b_waddr  = cmp_idx_q;
    b_we     = 1'b0;
    b_wdata  = aged;
    unique case (state_q)
      ST_CLK_RD: begin
        b_raddr = h_q;
      end
      ST_CLK_EV: begin
        b_raddr = h_q;
        b_waddr = h_q;
        b_wdata = '{refd: 1'b0, dirty: b_rdata.dirty, age: b_rdata.age};
        b_we    = b_rdata.refd;
      end
      ST_RDF: begin
        pg_raddr = f_q;
        b_raddr  = f_q;
      end
      ST_AGE: begin
        b_we = cmp_vld_q;
      end
      ST_DONE: begin
        pg_we = !hit_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      policy_q      <= POL_LRU;
      page_shift_q  <= 5'd12;
      frame_count_q <= CFG_W'(64);
      filled_q      <= '0;
      hand_q        <= '0;
      hit_cnt_q     <= '0;
      fault_cnt_q   <= '0;
      wb_cnt_q      <= '0;
      done_q        <= 1'b0;
      cmp_vld_q     <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_POLICY:      policy_q      <= cfg_data_i[1:0];
          REG_PAGE_SHIFT:  page_shift_q  <= cfg_data_i[4:0];
          REG_FRAME_COUNT: frame_count_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      unique case (state_q)
        ST_IDLE: begin
          if (start) begin
            page_q    <= page_in;
            wr_q      <= is_write_i;
            eff_q     <= eff_in;
            active_q  <= active_in;
            rd_cnt_q  <= '0;
            cmp_vld_q <= 1'b0;
            hit_q     <= 1'b0;
            ev_q      <= 1'b0;
            wb_q      <= 1'b0;
            vpage_q   <= '0;
            state_q   <= ST_SRCH;
          end
        end
        ST_SRCH: begin
          // One tag read issued per cycle, compared in the next.
          if (cmp_vld_q && (pg_rdata == page_q)) begin
            hit_q   <= 1'b1;
            f_q     <= cmp_idx_q;
            state_q <= ST_RDF;
          end else if (rd_cnt_q < active_q) begin
            cmp_idx_q <= rd_cnt_q[IW-1:0];
            cmp_vld_q <= 1'b1;
            rd_cnt_q  <= rd_cnt_q + CNT_W'(1);
          end else begin
            cmp_vld_q <= 1'b0;
            rd_cnt_q  <= '0;
            if (filled_q < eff_q) begin
              f_q       <= filled_q[IW-1:0];
              filled_q  <= filled_q + CNT_W'(1);
              old_age_q <= (AGE_W + 1)'(NUM_FRAMES);
              state_q   <= ST_AGE;
            end else begin
              ev_q <= 1'b1;
              if (policy_q == POL_CLOCK) begin
                h_q     <= h_start;
                state_q <= ST_CLK_RD;
              end else begin
                best_vld_q <= 1'b0;
                state_q    <= ST_SCAN;
              end
            end
          end
        end
        ST_SCAN: begin
          if (cmp_vld_q && (!best_vld_q || (scan_key > best_key_q))) begin
            best_vld_q <= 1'b1;
            best_key_q <= scan_key;
            best_idx_q <= cmp_idx_q;
          end
          if (rd_cnt_q < active_q) begin
            cmp_idx_q <= rd_cnt_q[IW-1:0];
            cmp_vld_q <= 1'b1;
            rd_cnt_q  <= rd_cnt_q + CNT_W'(1);
          end else begin
            cmp_vld_q <= 1'b0;
            if (!cmp_vld_q) begin
              f_q     <= best_idx_q;
              state_q <= ST_RDF;
            end
          end
        end
        ST_CLK_RD: begin
          state_q <= ST_CLK_EV;
        end
        ST_CLK_EV: begin
          // A referenced frame gets its second chance: bit cleared, hand moves on.
          if (b_rdata.refd) begin
            h_q     <= h_next;
            state_q <= ST_CLK_RD;
          end else begin
            f_q     <= h_q;
            hand_q  <= h_next;
            state_q <= ST_RDF;
          end
        end
        ST_RDF: begin
          state_q <= ST_GETF;
        end
        ST_GETF: begin
          old_age_q <= {1'b0, b_rdata.age};
          if (ev_q) begin
            vpage_q <= pg_rdata;
            wb_q    <= b_rdata.dirty;
          end
          rd_cnt_q  <= '0;
          cmp_vld_q <= 1'b0;
          state_q   <= ST_AGE;
        end
        ST_AGE: begin
          // Read entry i while entry i-1 is written back with its new age.
          if (rd_cnt_q < filled_q) begin
            cmp_idx_q <= rd_cnt_q[IW-1:0];
            cmp_vld_q <= 1'b1;
            rd_cnt_q  <= rd_cnt_q + CNT_W'(1);
          end else begin
            cmp_vld_q <= 1'b0;
            if (!cmp_vld_q) begin
              state_q <= ST_DONE;
            end
          end
        end
        ST_DONE: begin
          if (hit_q) begin
            hit_cnt_q <= hit_cnt_q + 32'd1;
          end else begin
            fault_cnt_q <= fault_cnt_q + 32'd1;
          end
          if (wb_q) begin
            wb_cnt_q <= wb_cnt_q + 32'd1;
          end
          done_q  <= 1'b1;
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy              = (state_q != ST_IDLE);
  assign done_o            = done_q;
  assign hit_o             = hit_q;
  assign evicted_o         = ev_q;
  assign writeback_o       = wb_q;
  assign victim_page_o     = VPAGE_W'(vpage_q);
  assign hit_total_o       = hit_cnt_q;
  assign fault_total_o     = fault_cnt_q;
  assign writeback_total_o = wb_cnt_q;

endmodule
